### rtl/rm_pkg.sv
package rm_pkg;

    localparam int DATA_W           = 32;
    localparam int HELD_W           = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef logic signed [DATA_W-1:0] sample_t;

    // Operation that one chain performs on an accepted word.
    localparam logic [1:0] OP_NONE       = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_POP_INSERT = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        sample_t    value;
    } chain_ctrl_t;

    typedef struct packed {
        sample_t sample;
        logic    end_of_stream;
    } rm_in_t;

    typedef struct packed {
        sample_t           median_out;
        logic [HELD_W-1:0] held_count;
        logic              store_full;
        logic              last_out;
    } rm_out_t;

endpackage

### rtl/rm_in_if.sv
interface rm_in_if
    import rm_pkg::*;
();
    logic   valid;
    logic   ready;
    rm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/rm_out_if.sv
interface rm_out_if
    import rm_pkg::*;
();
    logic    valid;
    logic    ready;
    rm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/rm_cell.sv
module rm_cell
    import rm_pkg::*;
#(
    parameter bit DESCEND = 1'b0,
    parameter bit HEAD    = 1'b0
) (
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  logic        valid,
    input  sample_t     prev_val,
    input  logic        prev_after,
    input  sample_t     next_val,
    input  logic        next_after,
    input  logic        next_valid,
    output sample_t     val,
    output logic        after
);

    sample_t val_reg;
    sample_t val_next;

    // The cell belongs behind the incoming value in chain order.
    assign after = valid && (DESCEND ? (val_reg < ctrl.value) : (val_reg > ctrl.value));
    assign val   = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (valid && !after)
                    val_next = val_reg;
                else if (HEAD || !prev_after)
                    val_next = ctrl.value;
                else
                    val_next = prev_val;
            end
            OP_POP_INSERT:
            begin
                // The head leaves; cells ahead of the new value move one cell toward the head.
                if (next_valid && !next_after)
                    val_next = next_val;
                else if (HEAD || !after)
                    val_next = ctrl.value;
                else
                    val_next = val_reg;
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### rtl/rm_chain.sv
module rm_chain
    import rm_pkg::*;
#(
    parameter int DEPTH   = DEFAULT_CAPACITY / 2,
    parameter int CNT_W   = $clog2(DEFAULT_CAPACITY + 1),
    parameter bit DESCEND = 1'b0
) (
    input  logic             clk,
    input  chain_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] cnt,
    output sample_t          head
);

    sample_t    vals  [DEPTH];
    logic       after [DEPTH];
    logic       valid [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            sample_t prev_v;
            logic    prev_a;
            sample_t next_v;
            logic    next_a;
            logic    next_ok;

            assign valid[i] = (cnt > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign prev_v = vals[i];
                assign prev_a = 1'b0;
            end
            else
            begin : g_mid
                assign prev_v = vals[i-1];
                assign prev_a = after[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_v  = vals[i];
                assign next_a  = 1'b0;
                assign next_ok = 1'b0;
            end
            else
            begin : g_inner
                assign next_v  = vals[i+1];
                assign next_a  = after[i+1];
                assign next_ok = valid[i+1];
            end

            rm_cell #(
                .DESCEND (DESCEND),
                .HEAD    (i == 0)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid[i]),
                .prev_val   (prev_v),
                .prev_after (prev_a),
                .next_val   (next_v),
                .next_after (next_a),
                .next_valid (next_ok),
                .val        (vals[i]),
                .after      (after[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule

### rtl/running_median.sv
// Running median of a stream of signed 32-bit samples.
// Input channel "samples" carries one word per sample with an end-of-stream
// mark; output channel "medians" returns exactly one word per input word with
// the median of all samples held, the held count, a full flag and the echoed
// end-of-stream mark. Both channels transfer a word when valid and ready are
// high at a rising clock edge.
// The samples live in two cell chains: the lower half sorted descending and
// the upper half sorted ascending, so the middle values always sit in the two
// head cells. Each accepted sample that fits is inserted, with at most one
// head value handed across to keep the halves balanced.
// A result word passes through the pending stage and then the output
// register after its sample is taken, and the block accepts one sample per
// cycle as long as the output drains.
// When the receiver stalls, one result waits in the output register and one
// more in the pending stage; input ready then drops until the output moves.
// When the store holds CAPACITY samples, a new sample is dropped and its word
// reports the unchanged median with store_full set. End of stream empties the
// store after its word is formed. Reset empties the store and both stages.
module running_median
    import rm_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    rm_in_if.sink         samples,
    rm_out_if.source      medians
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int L_DEPTH = (CAPACITY + 1) / 2;
    localparam int U_DEPTH = CAPACITY / 2;

    logic [CNT_W-1:0] nl_reg, nl_next;
    logic [CNT_W-1:0] nu_reg, nu_next;
    logic             p_valid_reg, p_valid_next;
    logic [CNT_W-1:0] p_count_reg, p_count_next;
    logic             p_full_reg, p_full_next;
    logic             p_last_reg, p_last_next;
    logic             o_valid_reg, o_valid_next;
    rm_out_t          o_data_reg, o_data_next;

    chain_ctrl_t      l_ctrl, u_ctrl;
    sample_t          l_head, u_head, x;
    logic [CNT_W-1:0] total;
    logic             full, even, accept, advance;
    logic signed [DATA_W:0] pair_sum, pair_adj;
    sample_t          median;

    rm_chain #(
        .DEPTH   (L_DEPTH),
        .CNT_W   (CNT_W),
        .DESCEND (1'b1)
    ) u_lower (
        .clk  (clk),
        .ctrl (l_ctrl),
        .cnt  (nl_reg),
        .head (l_head)
    );

    rm_chain #(
        .DEPTH   (U_DEPTH),
        .CNT_W   (CNT_W),
        .DESCEND (1'b0)
    ) u_upper (
        .clk  (clk),
        .ctrl (u_ctrl),
        .cnt  (nu_reg),
        .head (u_head)
    );

    // The output register frees up when it is empty or being read.
    assign advance       = !o_valid_reg || medians.ready;
    assign samples.ready = !p_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    assign x     = samples.data.sample;
    assign total = nl_reg + nu_reg;
    assign full  = (total >= CNT_W'(CAPACITY));
    assign even  = (nl_reg == nu_reg);

    // Route the sample into one half; rebalance by moving a head across.
    always_comb
    begin
        l_ctrl.op    = OP_NONE;
        l_ctrl.value = x;
        u_ctrl.op    = OP_NONE;
        u_ctrl.value = x;
        nl_next      = nl_reg;
        nu_next      = nu_reg;
        if (accept && !full)
        begin
            if (even)
            begin
                nl_next = nl_reg + 1'b1;
                l_ctrl.op = OP_INSERT;
                if (nu_reg != '0 && x > u_head)
                begin
                    l_ctrl.value = u_head;
                    u_ctrl.op    = OP_POP_INSERT;
                end
            end
            else
            begin
                nu_next = nu_reg + 1'b1;
                u_ctrl.op = OP_INSERT;
                if (x < l_head)
                begin
                    u_ctrl.value = l_head;
                    l_ctrl.op    = OP_POP_INSERT;
                end
            end
        end
        if (accept && samples.data.end_of_stream)
        begin
            nl_next = '0;
            nu_next = '0;
        end
    end

    // The pending stage holds the word's flags while the chains settle.
    always_comb
    begin
        p_valid_next = p_valid_reg;
        p_count_next = p_count_reg;
        p_full_next  = p_full_reg;
        p_last_next  = p_last_reg;
        if (p_valid_reg && advance)
            p_valid_next = 1'b0;
        if (accept)
        begin
            p_valid_next = 1'b1;
            p_count_next = full ? total : total + 1'b1;
            p_full_next  = full;
            p_last_next  = samples.data.end_of_stream;
        end
    end

    // The even-count median is the halved wide sum, truncated toward zero.
    assign pair_sum = {l_head[DATA_W-1], l_head} + {u_head[DATA_W-1], u_head};
    assign pair_adj = pair_sum + (DATA_W + 1)'(pair_sum[DATA_W]);

    always_comb
    begin
        if (p_count_reg == '0)
            median = '0;
        else if (p_count_reg[0])
            median = l_head;
        else
            median = pair_adj[DATA_W:1];
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_data_next  = o_data_reg;
        if (advance)
        begin
            o_valid_next = p_valid_reg;
            if (p_valid_reg)
            begin
                o_data_next.median_out = median;
                o_data_next.held_count = HELD_W'(p_count_reg);
                o_data_next.store_full = p_full_reg;
                o_data_next.last_out   = p_last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg      <= '0;
            nu_reg      <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            nl_reg      <= nl_next;
            nu_reg      <= nu_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_count_reg <= p_count_next;
        p_full_reg  <= p_full_next;
        p_last_reg  <= p_last_next;
        o_data_reg  <= o_data_next;
    end

    assign medians.valid = o_valid_reg;
    assign medians.data  = o_data_reg;

endmodule

### sim/running_median_tb.sv
module running_median_tb;
    import rm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default store size, and the predictor follows it.
    localparam int STORE_CAP       = DEFAULT_CAPACITY;
    localparam int WORDS_PER_PHASE = 235;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_PRINTED     = 40;

    localparam sample_t SAMPLE_MAX = sample_t'(32'h7FFF_FFFF);
    localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);

    // The median tracker keeps its own sorted copy of the held samples.
    // Each accepted sample word is turned into the result word the block should
    // return, and the result words are queued in arrival order. The block
    // answers every sample with exactly one word, so the oldest queued word is
    // always the one to compare.
    class median_scoreboard;
        sample_t held_samples[$];
        rm_out_t expected_medians[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function sample_t median_of_held();
            int n;
            longint pair_sum;
            n = held_samples.size();
            if (n == 0)
                return '0;
            if (n % 2 == 1)
                return held_samples[n / 2];
            // The sum is taken at 64 bits, so two extreme samples cannot wrap.
            // Integer division truncates toward zero, as the block must.
            pair_sum = longint'(held_samples[n / 2 - 1]) + longint'(held_samples[n / 2]);
            return sample_t'(pair_sum / 2);
        endfunction

        function void note_sample(rm_in_t word);
            rm_out_t result;
            int pos;
            result.store_full = 1'b0;
            if (held_samples.size() >= STORE_CAP) begin
                // A full store drops the sample and keeps its median.
                result.store_full = 1'b1;
            end
            else begin
                pos = held_samples.size();
                while (pos > 0 && held_samples[pos - 1] > word.sample)
                    pos--;
                held_samples.insert(pos, word.sample);
            end
            result.median_out = median_of_held();
            result.held_count = HELD_W'(held_samples.size());
            result.last_out   = word.end_of_stream;
            // End of stream empties the store only after its result is formed.
            if (word.end_of_stream)
                held_samples.delete();
            expected_medians.insert(expected_medians.size(), result);
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(rm_out_t got);
            rm_out_t want;
            if (expected_medians.size() == 0) begin
                report("result word with no sample waiting", 1, 0);
                return;
            end
            want = expected_medians.pop_front();
            if (got.median_out !== want.median_out)
                report("median_out", longint'(got.median_out), longint'(want.median_out));
            if (got.held_count !== want.held_count)
                report("held_count", longint'(got.held_count), longint'(want.held_count));
            if (got.store_full !== want.store_full)
                report("store_full", longint'(got.store_full), longint'(want.store_full));
            if (got.last_out !== want.last_out)
                report("last_out", longint'(got.last_out), longint'(want.last_out));
        endtask

        function int waiting();
            return expected_medians.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rm_in_if  samples_if ();
    rm_out_if medians_if ();

    running_median #(
        .CAPACITY(STORE_CAP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .medians (medians_if)
    );

    median_scoreboard tracker;

    // Idle rates in percent, changed from one phase of the run to the next.
    int send_idle_pct;
    int recv_stall_pct;

    // The main process asks for a long receiver hold-off through this flag;
    // the receiver process then counts the stretch down on its own.
    bit hold_request;
    int hold_left;

    int words_sent;

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Offer one sample word and wait for the block to take it. Idle cycles are
    // inserted ahead of the word at the current sender rate. The word is noted
    // in the tracker at the edge where it is taken; its result can only come
    // out after the pending stage and the output register, so the expectation is always queued first.
    task automatic offer(sample_t value, bit last);
        rm_in_t word;
        word.sample        = value;
        word.end_of_stream = last;
        while ($urandom_range(99) < send_idle_pct) begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.data  <= word;
        do
            @(posedge clk);
        while (!samples_if.ready);
        tracker.note_sample(word);
        words_sent++;
    endtask

    // Samples lean on the extremes and on a narrow band around zero, so that
    // duplicates, overflowing pair sums and negative halves come up often.
    // Full-range draws make every bit of the field take both values.
    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return sample_t'(int'($urandom_range(20)) - 10);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // One stream is a run of samples whose last word carries end of stream.
    task automatic send_stream(int length);
        for (int i = 0; i < length; i++)
            offer(random_sample(), i == length - 1);
    endtask

    // Most streams are short to medium; some are long enough to fill the
    // store and push a few samples past it, so rejection is seen regularly.
    function automatic int stream_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return $urandom_range(STORE_CAP + 6, STORE_CAP - 4);
        if (pick < 20)
            return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // Receiver: at each edge, take any word that moved, then choose ready for
    // the next cycle. A requested hold-off keeps ready low for a counted stretch.
    initial
    begin
        hold_left = 0;
        medians_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && medians_if.valid && medians_if.ready)
                tracker.check_result(medians_if.data);
            if (hold_request) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (!rst_n || hold_left > 0) begin
                medians_if.ready <= 1'b0;
                if (hold_left > 0)
                    hold_left--;
            end
            else begin
                medians_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: the slowest correct run takes well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int send_rates[4];
        int recv_rates[4];
        int drain_wait;

        // Phases: no idling, sender mostly idle, receiver mostly stalling,
        // and both idling now and then.
        send_rates = '{0, 81, 0, 24};
        recv_rates = '{0, 0, 81, 24};

        tracker        = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        words_sent     = 0;

        rst_n = 1'b0;
        samples_if.valid <= 1'b0;
        samples_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first stream stacks the extremes: two maxima
        // must average without wrapping, and the minimum beside the maximum
        // gives minus one half, which truncates to zero.
        offer(SAMPLE_MAX, 1'b0);
        offer(SAMPLE_MAX, 1'b0);
        offer(SAMPLE_MIN, 1'b0);
        offer(SAMPLE_MIN, 1'b0);
        offer(SAMPLE_MIN, 1'b1);
        // Two minima must average without wrapping either.
        offer(SAMPLE_MIN, 1'b0);
        offer(SAMPLE_MIN, 1'b1);
        // Small values: a negative odd pair sum truncates toward zero.
        offer(-3, 1'b0);
        offer(0, 1'b0);
        offer(3, 1'b0);
        offer(4, 1'b0);
        offer(-1, 1'b1);
        // A stream of one word, then a stream of equal samples.
        offer(0, 1'b1);
        offer(7, 1'b0);
        offer(7, 1'b0);
        offer(7, 1'b0);
        offer(7, 1'b1);
        // Values arriving in no sorted order, all ones and a lone bit.
        offer(-1, 1'b0);
        offer(sample_t'(32'h4000_0000), 1'b0);
        offer(sample_t'(32'h0000_0001), 1'b0);
        offer(-2, 1'b1);

        // Random part, in four idling phases. The first phase opens with a
        // stream that overfills the store and ends on a rejected sample,
        // while the receiver holds off long enough for the block to back up
        // and drop its input ready.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_rates[phase];
            recv_stall_pct = recv_rates[phase];
            if (phase == 0) begin
                hold_request = 1'b1;
                send_stream(STORE_CAP + 2);
            end
            while (words_sent < 21 + (phase + 1) * WORDS_PER_PHASE)
                send_stream(stream_length());
        end
        samples_if.valid <= 1'b0;

        // Let every result come back, then keep watching for a
        // stray word. The watchdog covers a block that never drains.
        while (tracker.waiting() != 0)
            @(posedge clk);
        for (drain_wait = 0; drain_wait < DRAIN_CYCLES; drain_wait++)
            @(posedge clk);

        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### running_median.f
rtl/rm_pkg.sv
rtl/rm_in_if.sv
rtl/rm_out_if.sv
rtl/rm_cell.sv
rtl/rm_chain.sv
rtl/running_median.sv
sim/running_median_tb.sv
